// File: src/crs_pkg.sv
package crs_pkg;

	localparam int COORD_W = 32;
	localparam int IDX_W   = 6;
	localparam int POS_W   = 23;
	localparam int CNT_W   = 7;
	localparam int AXES    = 3;
	localparam int TAPS    = 4;

	// horner accumulator: coefficients and partial sums stay below 2^37
	localparam int ACC_W = 38;

	localparam logic [CNT_W-1:0] CNT_RESET = 7'd4;

	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_EVAL = 1'b1;

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef coord_t [AXES-1:0] point_t;
	typedef point_t [TAPS-1:0] quad_t;

	localparam coord_t COORD_MAX = 32'sh7fff_ffff;
	localparam coord_t COORD_MIN = 32'sh8000_0000;

	typedef struct packed {
		logic               op;
		logic [IDX_W-1:0]   point_index;
		coord_t             point_x;
		coord_t             point_y;
		coord_t             point_z;
		logic [POS_W-1:0]   curve_position;
	} item_t;

	typedef struct packed {
		coord_t out_x;
		coord_t out_y;
		coord_t out_z;
	} result_t;

endpackage

// File: src/crs_front.sv
module crs_front import crs_pkg::*; #(
	parameter int MAX_POINTS = 64,
	parameter int FRAC_BITS  = 16,
	parameter int Q_DEPTH    = 4
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             item_valid,
	output logic                             item_ready,
	input  item_t                            item,
	input  logic [CNT_W-1:0]                 cnt,
	input  logic [$clog2(Q_DEPTH + 1)-1:0]   q_count,
	output logic                             push,
	output quad_t                            quad,
	output logic [FRAC_BITS-1:0]             u
);

	localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
	localparam int XW = ((POS_W > AW + 1) ? POS_W : AW + 1) + 2;
	localparam int CW = $clog2(Q_DEPTH + 1);

	logic                 take;
	logic                 is_load;
	logic                 is_eval;
	logic                 rd_en;
	logic                 wr_en;
	logic [CW:0]          busy;
	logic [XW-1:0]        posx;
	logic [XW-1:0]        ip;
	logic [XW-1:0]        nx;
	logic [XW-1:0]        last;
	logic [XW-1:0]        k;
	logic [XW-1:0]        slot;
	logic [XW-1:0]        sel [TAPS];
	logic [AW-1:0]        rd_addr [TAPS];
	logic [AW-1:0]        wr_addr;
	point_t               wr_pt;
	point_t               rd_s1 [TAPS];
	logic                 eval_s1;
	logic [FRAC_BITS-1:0] u_s1;

	// words in the read stage count against queue room
	assign busy       = (CW + 1)'(q_count) + (CW + 1)'(eval_s1);
	assign item_ready = busy < (CW + 1)'(Q_DEPTH);
	assign take       = item_valid && item_ready;
	assign is_load    = item.op == OP_LOAD;
	assign is_eval    = item.op == OP_EVAL;
	assign rd_en      = take && is_eval;

	assign slot    = XW'(item.point_index);
	assign wr_addr = slot[AW-1:0];
	assign wr_en   = take && is_load && (slot < XW'(MAX_POINTS));

	always_comb begin
		wr_pt[0] = item.point_x;
		wr_pt[1] = item.point_y;
		wr_pt[2] = item.point_z;
	end

	always_comb begin
		posx = XW'(item.curve_position);
		ip   = posx >> FRAC_BITS;
		nx   = XW'(cnt);
		if (nx == '0) begin
			nx = XW'(1);
		end else if (nx > XW'(MAX_POINTS)) begin
			nx = XW'(MAX_POINTS);
		end
		last = nx - XW'(1);
		k    = (posx == '0) ? '0 : last;
		// endpoints: all four taps on one point makes the cubic return it exactly
		if (posx == '0 || ip >= nx) begin
			for (int j = 0; j < TAPS; j++) begin
				sel[j] = k;
			end
		end else begin
			sel[0] = (ip == '0) ? '0 : ip - XW'(1);
			sel[1] = ip;
			sel[2] = (ip + XW'(1) >= nx) ? last : ip + XW'(1);
			sel[3] = (ip + XW'(2) >= nx) ? last : ip + XW'(2);
		end
		for (int j = 0; j < TAPS; j++) begin
			rd_addr[j] = sel[j][AW-1:0];
		end
	end

	// one table copy per tap so all four neighbors are read in the same cycle
	for (genvar b = 0; b < TAPS; b++) begin : g_bank
		point_t bank_mem [MAX_POINTS];

		always_ff @(posedge clk) begin
			if (wr_en) begin
				bank_mem[wr_addr] <= wr_pt;
			end
			if (rd_en) begin
				rd_s1[b] <= bank_mem[rd_addr[b]];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eval_s1 <= 1'b0;
		end else begin
			eval_s1 <= rd_en;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			u_s1 <= posx[FRAC_BITS-1:0];
		end
	end

	always_comb begin
		for (int j = 0; j < TAPS; j++) begin
			quad[j] = rd_s1[j];
		end
	end

	assign push = eval_s1;
	assign u    = u_s1;

endmodule

// File: src/crs_queue.sv
module crs_queue #(
	parameter int W     = 8,
	parameter int DEPTH = 4
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           push,
	input  logic [W-1:0]                   wdata,
	input  logic                           pop,
	output logic                           head_valid,
	output logic [W-1:0]                   rdata,
	output logic [$clog2(DEPTH + 1)-1:0]   count
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [W-1:0]  slots [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			count_q <= count_q + CW'(push) - CW'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slots[wr_ptr_q] <= wdata;
		end
	end

	assign head_valid = count_q != '0;
	assign rdata      = slots[rd_ptr_q];
	assign count      = count_q;

endmodule

// File: src/crs_back.sv
module crs_back import crs_pkg::*; #(
	parameter int FRAC_BITS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  quad_t                quad,
	input  logic [FRAC_BITS-1:0] u,
	output logic                 result_valid,
	input  logic                 result_ready,
	output result_t              result
);

	localparam int MW = ACC_W + FRAC_BITS + 1;

	logic adv;

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, res_valid_q;

	logic signed [ACC_W-1:0] a_s1 [AXES], b_s1 [AXES], c_s1 [AXES], d_s1 [AXES];
	logic signed [ACC_W-1:0] a_s2 [AXES], b_s2 [AXES], c_s2 [AXES];
	logic signed [MW-1:0]    m_s2 [AXES];
	logic signed [ACC_W-1:0] a_s3 [AXES], b_s3 [AXES], acc_s3 [AXES];
	logic signed [ACC_W-1:0] a_s4 [AXES], b_s4 [AXES];
	logic signed [MW-1:0]    m_s4 [AXES];
	logic signed [ACC_W-1:0] a_s5 [AXES], acc_s5 [AXES];
	logic signed [ACC_W-1:0] a_s6 [AXES];
	logic signed [MW-1:0]    m_s6 [AXES];
	logic [FRAC_BITS-1:0]    u_s1, u_s2, u_s3, u_s4, u_s5;
	result_t                 res_q;

	logic signed [ACC_W-1:0] pe [TAPS][AXES];
	logic signed [ACC_W-1:0] a_n [AXES], b_n [AXES], c_n [AXES], d_n [AXES];
	logic signed [MW-1:0]    m2_n [AXES], m4_n [AXES], m6_n [AXES];
	logic signed [ACC_W-1:0] acc3_n [AXES], acc5_n [AXES], sum7 [AXES], half7 [AXES];
	logic signed [FRAC_BITS:0] us1, us3, us5;
	coord_t                  sat7 [AXES];
	result_t                 res_n;

	// whole pipeline moves together, held only while the output word waits
	assign adv      = !res_valid_q || result_ready;
	assign in_ready = adv;

	assign us1 = $signed({1'b0, u_s1});
	assign us3 = $signed({1'b0, u_s3});
	assign us5 = $signed({1'b0, u_s5});

	always_comb begin
		for (int ax = 0; ax < AXES; ax++) begin
			for (int t = 0; t < TAPS; t++) begin
				pe[t][ax] = ACC_W'($signed(quad[t][ax]));
			end
			a_n[ax] = pe[1][ax] <<< 1;
			b_n[ax] = pe[2][ax] - pe[0][ax];
			c_n[ax] = (pe[0][ax] <<< 1) - ((pe[1][ax] <<< 2) + pe[1][ax])
				+ (pe[2][ax] <<< 2) - pe[3][ax];
			d_n[ax] = (pe[1][ax] - pe[2][ax]) + ((pe[1][ax] - pe[2][ax]) <<< 1)
				+ pe[3][ax] - pe[0][ax];

			m2_n[ax]   = MW'(d_s1[ax]) * MW'(us1);
			acc3_n[ax] = c_s2[ax] + ACC_W'(m_s2[ax] >>> FRAC_BITS);
			m4_n[ax]   = MW'(acc_s3[ax]) * MW'(us3);
			acc5_n[ax] = b_s4[ax] + ACC_W'(m_s4[ax] >>> FRAC_BITS);
			m6_n[ax]   = MW'(acc_s5[ax]) * MW'(us5);
			sum7[ax]   = a_s6[ax] + ACC_W'(m_s6[ax] >>> FRAC_BITS);
			half7[ax]  = sum7[ax] >>> 1;

			// fits when all bits above the sign of a 32-bit word agree
			if (&half7[ax][ACC_W-1:COORD_W-1] || ~|half7[ax][ACC_W-1:COORD_W-1]) begin
				sat7[ax] = half7[ax][COORD_W-1:0];
			end else if (half7[ax][ACC_W-1]) begin
				sat7[ax] = COORD_MIN;
			end else begin
				sat7[ax] = COORD_MAX;
			end
		end
		res_n.out_x = sat7[0];
		res_n.out_y = sat7[1];
		res_n.out_z = sat7[2];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			v_s4        <= 1'b0;
			v_s5        <= 1'b0;
			v_s6        <= 1'b0;
			res_valid_q <= 1'b0;
		end else if (adv) begin
			v_s1        <= in_valid;
			v_s2        <= v_s1;
			v_s3        <= v_s2;
			v_s4        <= v_s3;
			v_s5        <= v_s4;
			v_s6        <= v_s5;
			res_valid_q <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int ax = 0; ax < AXES; ax++) begin
				a_s1[ax]   <= a_n[ax];
				b_s1[ax]   <= b_n[ax];
				c_s1[ax]   <= c_n[ax];
				d_s1[ax]   <= d_n[ax];
				a_s2[ax]   <= a_s1[ax];
				b_s2[ax]   <= b_s1[ax];
				c_s2[ax]   <= c_s1[ax];
				m_s2[ax]   <= m2_n[ax];
				a_s3[ax]   <= a_s2[ax];
				b_s3[ax]   <= b_s2[ax];
				acc_s3[ax] <= acc3_n[ax];
				a_s4[ax]   <= a_s3[ax];
				b_s4[ax]   <= b_s3[ax];
				m_s4[ax]   <= m4_n[ax];
				a_s5[ax]   <= a_s4[ax];
				acc_s5[ax] <= acc5_n[ax];
				a_s6[ax]   <= a_s5[ax];
				m_s6[ax]   <= m6_n[ax];
			end
			u_s1  <= u;
			u_s2  <= u_s1;
			u_s3  <= u_s2;
			u_s4  <= u_s3;
			u_s5  <= u_s4;
			res_q <= res_n;
		end
	end

	assign result_valid = res_valid_q;
	assign result       = res_q;

endmodule

// File: src/catmull_rom_spline_eval.sv
// Uniform Catmull-Rom evaluator over a table of signed Q16.16 3D control points. A load word
// writes one point into four copies of the point table; an evaluate word reads its four
// neighbor points, one from each copy, in the cycle it is accepted, passes through a
// four-entry queue and then a seven-stage Horner pipeline (three multiplies per axis,
// one per stage pair) that ends in the output register. One word is taken per cycle while
// item_ready is high, loads and evaluates mixed freely. A stalled output holds the Horner
// pipeline, while the front keeps taking words until the queue is full. A point count
// written on cfg_wr_data of zero acts as one and values above MAX_POINTS act as MAX_POINTS;
// loads to slots at or beyond MAX_POINTS are dropped. Evaluating a slot never loaded since
// reset gives an undefined result.
module catmull_rom_spline_eval import crs_pkg::*; #(
	parameter int MAX_POINTS = 64,
	parameter int FRAC_BITS  = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_wr_en,
	input  logic [CNT_W-1:0] cfg_wr_data,
	input  logic             item_valid,
	output logic             item_ready,
	input  item_t            item,
	output logic             result_valid,
	input  logic             result_ready,
	output result_t          result
);

	localparam int Q_DEPTH = 4;
	localparam int CW      = $clog2(Q_DEPTH + 1);
	localparam int QUAD_W  = TAPS * AXES * COORD_W;
	localparam int QW      = QUAD_W + FRAC_BITS;

	logic [CNT_W-1:0]     cnt_q;
	logic                 f_push;
	quad_t                f_quad;
	logic [FRAC_BITS-1:0] f_u;
	logic [CW-1:0]        q_count;
	logic                 q_valid;
	logic [QW-1:0]        q_rdata;
	logic                 b_ready;
	quad_t                b_quad;
	logic [FRAC_BITS-1:0] b_u;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= CNT_RESET;
		end else if (cfg_wr_en) begin
			cnt_q <= cfg_wr_data;
		end
	end

	crs_front #(
		.MAX_POINTS (MAX_POINTS),
		.FRAC_BITS  (FRAC_BITS),
		.Q_DEPTH    (Q_DEPTH)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.item       (item),
		.cnt        (cnt_q),
		.q_count    (q_count),
		.push       (f_push),
		.quad       (f_quad),
		.u          (f_u)
	);

	crs_queue #(
		.W     (QW),
		.DEPTH (Q_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (f_push),
		.wdata      ({f_u, f_quad}),
		.pop        (q_valid && b_ready),
		.head_valid (q_valid),
		.rdata      (q_rdata),
		.count      (q_count)
	);

	assign b_quad = q_rdata[QUAD_W-1:0];
	assign b_u    = q_rdata[QW-1:QUAD_W];

	crs_back #(
		.FRAC_BITS (FRAC_BITS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (q_valid),
		.in_ready     (b_ready),
		.quad         (b_quad),
		.u            (b_u),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

endmodule

// File: src/crs_check.sv
module crs_check import crs_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    item_valid,
	input  logic    item_ready,
	input  item_t   item,
	input  logic    result_valid,
	input  logic    result_ready,
	input  result_t result
);

	logic [5:0] pending_q;
	logic       ev_take;
	logic       res_take;

	assign ev_take  = item_valid && item_ready && item.op == OP_EVAL;
	assign res_take = result_valid && result_ready;

	// evaluate words taken but not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else begin
			pending_q <= pending_q + 6'(ev_take) - 6'(res_take);
		end
	end

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result))
		else $error("result word dropped or changed while stalled");

	a_no_extra_result: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> pending_q != 6'd0)
		else $error("result word with no evaluate word outstanding");

	a_idle_ready: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q == 6'd0 |-> item_ready)
		else $error("input not ready although nothing is in flight");

	a_reset_quiet: assert property (@(posedge clk)
		!arst_n |-> !result_valid)
		else $error("result valid during reset");

endmodule

bind catmull_rom_spline_eval crs_check u_crs_check (.*);
